// ----- hw/rtl/conv_bias_lrelu_requant_residual_top_defines.svh -----
// assertion macros for the post-convolution requantise block
// expects a clock named clk and an active-high reset named rst in the including scope
`ifndef CONV_BIAS_LRELU_REQUANT_RESIDUAL_TOP_DEFINES_SVH
`define CONV_BIAS_LRELU_REQUANT_RESIDUAL_TOP_DEFINES_SVH

// same-cycle implication
`define CBLRR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CBLRR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/cblrr_pkg.sv -----
// shared types and constants for the post-convolution requantise block
// no dependencies
`timescale 1ns / 1ps

package cblrr_pkg;

  localparam int LANES      = 4;
  localparam int BIAS_DEPTH = 512;
  localparam int BIAS_AW    = 9;
  localparam int CNT_W      = 10;
  localparam int ADDR_W     = 4;

  typedef enum logic [1:0] {
    OP_BIAS    = 2'd0,
    OP_RESTART = 2'd1,
    OP_PROC    = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    REG_CHANNEL_COUNT   = 2'd0,
    REG_REQUANT_SHIFT   = 2'd1,
    REG_LANE_MODE       = 2'd2,
    REG_RESIDUAL_ENABLE = 2'd3
  } reg_idx_t;

  typedef enum logic {
    ST_RUN,
    ST_REDUCE
  } ctl_state_t;

  // per-lane pipeline controls, shared by all lanes
  typedef struct packed {
    logic                      bias_we;
    logic [BIAS_AW-1:0]        bias_waddr;
    logic signed [7:0]         bias_wdata;
    logic                      load_s1;
    logic                      load_s2;
    logic                      load_out;
    logic [4:0]                shift;
    logic                      res_en;
  } lane_ctrl_t;

endpackage

// ----- hw/rtl/cblrr_lane.sv -----
// one lane: bias table copy, bias add, leaky relu, requantise shift, residual add
// depends on cblrr_pkg
`timescale 1ns / 1ps

module cblrr_lane (
  input  logic                              clk,
  input  cblrr_pkg::lane_ctrl_t             ctrl,
  input  logic [cblrr_pkg::BIAS_AW-1:0]     rd_addr,
  input  logic signed [31:0]                psum,
  input  logic signed [8:0]                 residual,
  output logic signed [7:0]                 pixel
);

  logic signed [7:0]  bias_mem [cblrr_pkg::BIAS_DEPTH];

  // stage 1
  logic signed [7:0]  bias_q;
  logic signed [31:0] psum_q;
  logic signed [8:0]  res_s1;
  // stage 2
  logic signed [31:0] act_q;
  logic signed [8:0]  res_s2;

  logic signed [31:0] sum;
  logic signed [35:0] prod;
  logic signed [35:0] prod_sh;
  logic signed [31:0] act;
  logic signed [31:0] shifted;
  logic signed [7:0]  sat_a;
  logic signed [9:0]  res_sum;
  logic signed [7:0]  pix;

  function automatic logic signed [7:0] sat8_32(input logic signed [31:0] v);
    logic signed [7:0] r;
    if (v > 32'sd127) begin
      r = 8'sh7f;
    end else if (v < -32'sd128) begin
      r = 8'sh80;
    end else begin
      r = v[7:0];
    end
    return r;
  endfunction

  function automatic logic signed [7:0] sat8_10(input logic signed [9:0] v);
    logic signed [7:0] r;
    if (v > 10'sd127) begin
      r = 8'sh7f;
    end else if (v < -10'sd128) begin
      r = 8'sh80;
    end else begin
      r = v[7:0];
    end
    return r;
  endfunction

  // bias table copy: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (ctrl.bias_we) begin
      bias_mem[ctrl.bias_waddr] <= ctrl.bias_wdata;
    end
    if (ctrl.load_s1) begin
      bias_q <= bias_mem[rd_addr];
      psum_q <= psum;
      res_s1 <= residual;
    end
  end

  // bias add with 32-bit wrap, then for a negative sum x*13 as shifts and adds, floor by 128
  always_comb begin
    sum     = psum_q + 32'(bias_q);
    prod    = (36'(sum) <<< 3) + (36'(sum) <<< 2) + 36'(sum);
    prod_sh = prod >>> 7;
    act     = sum[31] ? prod_sh[31:0] : sum;
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_s2) begin
      act_q  <= act;
      res_s2 <= res_s1;
    end
  end

  always_comb begin
    shifted = act_q >>> ctrl.shift;
    sat_a   = sat8_32(shifted);
    res_sum = 10'(sat_a) + 10'(res_s2);
    pix     = ctrl.res_en ? sat8_10(res_sum) : sat_a;
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_out) begin
      pixel <= pix;
    end
  end

endmodule

// ----- hw/rtl/conv_bias_lrelu_requant_residual_top.sv -----
// top level of the post-convolution requantise block: handshake, config, channel position
// depends on cblrr_pkg, cblrr_lane and conv_bias_lrelu_requant_residual_top_defines.svh
//
// usage
//  - input channel in_valid / in_stall carries one item: an opcode plus its operands.
//    opcode 0 stores a bias byte, opcode 1 restarts the channel position, opcode 2
//    runs four partial sums through bias, leaky relu, shift, saturation and residual
//  - output channel out_valid / out_stall carries four int8 pixels, one item per
//    opcode 2 item, in order; other opcodes give nothing
//  - a process item passes bias read, activation and requantise on its way to the
//    output, each ending in a register; the first is loaded at the edge that takes it
//  - throughput: one item per cycle while in_stall is low; the three stages advance
//    independently, so bubbles close up and input is taken while a finished item
//    waits at the output
//  - out_stall holds the output register; once every stage is full, in_stall rises
//  - writing channel_count starts a remainder pass that folds the last position set
//    by an item below the new count; in_stall is high throughout
//  - reset clears the config registers (count 1), the position and all valid bits;
//    bias entries are undefined until written
//  - config port: apb-style, pready tied high, registers at byte offsets 0, 4, 8, 12
`timescale 1ns / 1ps
`include "conv_bias_lrelu_requant_residual_top_defines.svh"

module conv_bias_lrelu_requant_residual_top (
  input  logic                              clk,
  input  logic                              rst,
  // config port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [cblrr_pkg::ADDR_W-1:0]      paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  // input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        opcode,
  input  logic [8:0]                        bias_index,
  input  logic signed [7:0]                 bias_value,
  input  logic signed [31:0]                psum_0,
  input  logic signed [31:0]                psum_1,
  input  logic signed [31:0]                psum_2,
  input  logic signed [31:0]                psum_3,
  input  logic signed [8:0]                 residual_0,
  input  logic signed [8:0]                 residual_1,
  input  logic signed [8:0]                 residual_2,
  input  logic signed [8:0]                 residual_3,
  // output channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [7:0]                 pixel_0,
  output logic signed [7:0]                 pixel_1,
  output logic signed [7:0]                 pixel_2,
  output logic signed [7:0]                 pixel_3
);

  localparam int LN    = cblrr_pkg::LANES;
  localparam int AW    = cblrr_pkg::BIAS_AW;
  localparam int CW    = cblrr_pkg::CNT_W;
  localparam int RED_W = AW + CW;

  // config registers
  logic [CW-1:0]  channel_count;
  logic [4:0]     requant_shift;
  logic           lane_mode;
  logic           residual_enable;

  // channel position and remainder pass
  cblrr_pkg::ctl_state_t state, state_next;
  logic [AW-1:0]  pos, pos_next;
  // position as last set by a restart or process item, before any folding
  logic [AW-1:0]  pos_raw, pos_raw_next;
  logic [3:0]     red_k, red_k_next;
  logic [RED_W-1:0] red_div;
  logic           red_sub;

  // pipeline valid bits
  logic           s1_v, s2_v, out_v;
  logic           out_ready, s2_ready, s1_ready;
  logic           accept, cfg_wr, cnt_write;

  logic [CW-1:0]  n_eff;
  logic [AW-1:0]  adv;
  logic [AW-1:0]  ch [LN];

  logic signed [31:0]  psum_a [LN];
  logic signed [8:0]   res_a  [LN];
  logic signed [7:0]   pix_a  [LN];

  cblrr_pkg::lane_ctrl_t lane_ctrl;

  // count of 0 acts as 1, anything above the table depth as the depth
  function automatic logic [CW-1:0] eff_count(input logic [CW-1:0] c);
    logic [CW-1:0] r;
    if (c == '0) begin
      r = CW'(1);
    end else if (c > CW'(cblrr_pkg::BIAS_DEPTH)) begin
      r = CW'(cblrr_pkg::BIAS_DEPTH);
    end else begin
      r = c;
    end
    return r;
  endfunction

  // remainder of t by n, valid while t < n + LANES
  function automatic logic [AW-1:0] mod_small(input logic [CW-1:0] t, input logic [CW-1:0] n);
    logic [CW-1:0] r;
    r = t;
    for (int k = 0; k < LN; k++) begin
      if (r >= n) begin
        r = r - n;
      end
    end
    return r[AW-1:0];
  endfunction

  assign psum_a[0] = psum_0;
  assign psum_a[1] = psum_1;
  assign psum_a[2] = psum_2;
  assign psum_a[3] = psum_3;
  assign res_a[0]  = residual_0;
  assign res_a[1]  = residual_1;
  assign res_a[2]  = residual_2;
  assign res_a[3]  = residual_3;
  assign pixel_0   = pix_a[0];
  assign pixel_1   = pix_a[1];
  assign pixel_2   = pix_a[2];
  assign pixel_3   = pix_a[3];

  // ---------------------------------------------------------------- config port
  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite;
  assign cnt_write = cfg_wr && (paddr[3:2] == cblrr_pkg::REG_CHANNEL_COUNT);

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count   <= CW'(1);
      requant_shift   <= '0;
      lane_mode       <= 1'b0;
      residual_enable <= 1'b0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        cblrr_pkg::REG_CHANNEL_COUNT:   channel_count   <= pwdata[CW-1:0];
        cblrr_pkg::REG_REQUANT_SHIFT:   requant_shift   <= pwdata[4:0];
        cblrr_pkg::REG_LANE_MODE:       lane_mode       <= pwdata[0];
        cblrr_pkg::REG_RESIDUAL_ENABLE: residual_enable <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      cblrr_pkg::REG_CHANNEL_COUNT:   prdata = 32'(channel_count);
      cblrr_pkg::REG_REQUANT_SHIFT:   prdata = 32'(requant_shift);
      cblrr_pkg::REG_LANE_MODE:       prdata = 32'(lane_mode);
      cblrr_pkg::REG_RESIDUAL_ENABLE: prdata = 32'(residual_enable);
      default:                        prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- handshake
  // each stage takes a new item when it is empty or its item moves on
  assign out_ready = !out_v || !out_stall;
  assign s2_ready  = !s2_v || out_ready;
  assign s1_ready  = !s1_v || s2_ready;
  assign in_stall  = (state == cblrr_pkg::ST_REDUCE) || !s1_ready;
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_v;

  always_comb begin
    lane_ctrl.bias_we    = accept && (opcode == cblrr_pkg::OP_BIAS);
    lane_ctrl.bias_waddr = bias_index;
    lane_ctrl.bias_wdata = bias_value;
    lane_ctrl.load_s1    = accept && (opcode == cblrr_pkg::OP_PROC);
    lane_ctrl.load_s2    = s1_v && s2_ready;
    lane_ctrl.load_out   = s2_v && out_ready;
    lane_ctrl.shift      = requant_shift;
    lane_ctrl.res_en     = residual_enable;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v  <= 1'b0;
      s2_v  <= 1'b0;
      out_v <= 1'b0;
    end else begin
      if (lane_ctrl.load_s1) begin
        s1_v <= 1'b1;
      end else if (s2_ready) begin
        s1_v <= 1'b0;
      end
      if (lane_ctrl.load_s2) begin
        s2_v <= 1'b1;
      end else if (out_ready) begin
        s2_v <= 1'b0;
      end
      if (lane_ctrl.load_out) begin
        out_v <= 1'b1;
      end else if (!out_stall) begin
        out_v <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- channel position
  // position is kept below the effective count, so lane channels need at most
  // a few compare-and-subtract steps
  assign n_eff = eff_count(channel_count);

  always_comb begin
    for (int i = 0; i < LN; i++) begin
      ch[i] = lane_mode ? mod_small(CW'(pos) + CW'(i), n_eff) : pos;
    end
    if (lane_mode) begin
      adv = mod_small(CW'(pos) + CW'(LN), n_eff);
    end else if (CW'(pos) + CW'(1) == n_eff) begin
      adv = '0;
    end else begin
      adv = pos + AW'(1);
    end
  end

  // restoring remainder: subtract n shifted by red_k, from high k down to zero
  assign red_div = RED_W'(n_eff) << red_k;
  assign red_sub = RED_W'(pos) >= red_div;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= cblrr_pkg::ST_RUN;
      pos     <= '0;
      pos_raw <= '0;
      red_k   <= '0;
    end else begin
      state   <= state_next;
      pos     <= pos_next;
      pos_raw <= pos_raw_next;
      red_k   <= red_k_next;
    end
  end

  always_comb begin
    state_next   = state;
    pos_next     = pos;
    pos_raw_next = pos_raw;
    red_k_next   = red_k;
    case (state)
      cblrr_pkg::ST_RUN: begin
        if (accept) begin
          case (opcode)
            cblrr_pkg::OP_RESTART: begin
              pos_next     = '0;
              pos_raw_next = '0;
            end
            cblrr_pkg::OP_PROC: begin
              pos_next     = adv;
              pos_raw_next = adv;
            end
            default: ;
          endcase
        end
      end
      cblrr_pkg::ST_REDUCE: begin
        if (red_sub) begin
          pos_next = pos - red_div[AW-1:0];
        end
        if (red_k == '0) begin
          state_next = cblrr_pkg::ST_RUN;
        end else begin
          red_k_next = red_k - 4'd1;
        end
      end
      default: state_next = cblrr_pkg::ST_RUN;
    endcase
    // a new count restarts the pass from the top step, on the unfolded position
    if (cnt_write) begin
      state_next = cblrr_pkg::ST_REDUCE;
      red_k_next = 4'(AW);
      pos_next   = pos_raw_next;
    end
  end

  // ---------------------------------------------------------------- lanes
  for (genvar g = 0; g < LN; g++) begin : g_lane
    cblrr_lane u_lane (
      .clk      (clk),
      .ctrl     (lane_ctrl),
      .rd_addr  (ch[g]),
      .psum     (psum_a[g]),
      .residual (res_a[g]),
      .pixel    (pix_a[g])
    );
  end

  // ---------------------------------------------------------------- checks
  `CBLRR_ASSERT_NOW(a_pos_in_range, state == cblrr_pkg::ST_RUN, CW'(pos) < n_eff, "channel position at or beyond count")
  `CBLRR_ASSERT_NOW(a_no_take_reduce, state == cblrr_pkg::ST_REDUCE, !accept, "item taken during remainder pass")
  `CBLRR_ASSERT_NOW(a_out_from_s2, $rose(out_v), $past(s2_v), "result appeared without an item in stage 2")
  `CBLRR_ASSERT_NEXT(a_s1_holds, s1_v && !s2_ready, s1_v, "stage 1 item lost while stalled")

endmodule
